/* src/wsd_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; the modules refer to it by scoped names.

package wsd_pkg;

	localparam int LENGTH_BITS_DEF = 64;

	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXT16   = 3'd2,
		PH_EXT64   = 3'd3,
		PH_MASK    = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_CLOSED  = 3'd6
	} phase_t;

	// input stage contents
	typedef struct packed {
		logic       vld;
		logic [7:0] rx_byte;
	} in_s1_t;

	// one result item
	typedef struct packed {
		logic [7:0] data;
		logic       data_valid;
		logic       last;
		logic [3:0] opcode;
		logic       fin;
		logic       closed;
	} res_t;

endpackage

/* src/wsd_rx_if.sv */
// Byte channel into the deframer: valid/ready plus the received byte.
// No dependencies.

interface wsd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

/* src/wsd_frame_if.sv */
// Result channel out of the deframer: valid/ready plus the result fields.
// No dependencies.

interface wsd_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	logic       data_valid;
	logic       last;
	logic [3:0] opcode;
	logic       fin;
	logic       closed;

	modport source (output valid, output data, output data_valid, output last,
		output opcode, output fin, output closed, input ready);
	modport sink   (input valid, input data, input data_valid, input last,
		input opcode, input fin, input closed, output ready);
endinterface

/* src/wsd_in_reg.sv */
// Input register stage: captures one received byte per cycle while the stage is empty or its byte leaves.
// Depends on wsd_pkg and wsd_rx_if.

module wsd_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	wsd_rx_if.sink          rx,
	input  logic            adv,
	output wsd_pkg::in_s1_t stage
);

	logic       vld_s1;
	logic [7:0] byte_s1;

	// stage empty, or its item leaves this cycle
	assign rx.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx.ready) begin
			vld_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign stage.vld     = vld_s1;
	assign stage.rx_byte = byte_s1;

endmodule

/* src/wsd_parser.sv */
// Frame parser: header/length/mask state and payload unmasking for one byte.
// Depends on wsd_pkg.

module wsd_parser #(
	parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  wsd_pkg::in_s1_t stage,
	input  logic            slot_free,
	output logic            adv,
	output logic            load,
	output wsd_pkg::res_t   res
);

	wsd_pkg::phase_t        phase_q, phase_n;
	logic                   fin_q, fin_n;
	logic [3:0]             op_q, op_n;
	logic                   mask_q, mask_n;
	logic [LENGTH_BITS-1:0] len_q, len_n;   // length, then bytes remaining
	logic [2:0]             cnt_q, cnt_n;
	logic [31:0]            key_q, key_n;
	logic [1:0]             idx_q, idx_n;

	logic                   gen;
	logic                   do_after_len, do_hdr_done, do_end;
	logic [7:0]             end_d;
	logic                   end_v;
	logic [7:0]             b;
	logic [7:0]             key_byte;
	logic [7:0]             d;
	logic [LENGTH_BITS-1:0] len_push;

	assign b = stage.rx_byte;

	always_comb begin
		case (idx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	assign d = b ^ key_byte;

	// saturate once the top byte is occupied
	always_comb begin
		if (len_q[LENGTH_BITS-1 -: 8] != 8'd0) begin
			len_push = '1;
		end else begin
			len_push = {len_q[LENGTH_BITS-9:0], b};
		end
	end

	always_comb begin
		phase_n      = phase_q;
		fin_n        = fin_q;
		op_n         = op_q;
		mask_n       = mask_q;
		len_n        = len_q;
		cnt_n        = cnt_q;
		key_n        = key_q;
		idx_n        = idx_q;
		gen          = 1'b0;
		do_after_len = 1'b0;
		do_hdr_done  = 1'b0;
		do_end       = 1'b0;
		end_d        = 8'd0;
		end_v        = 1'b0;
		res          = '0;
		res.opcode   = op_q;
		res.fin      = fin_q;

		unique case (phase_q)
			wsd_pkg::PH_HDR1: begin
				mask_n = b[7];
				key_n  = '0;
				len_n  = '0;
				cnt_n  = '0;
				if (b[6:0] == wsd_pkg::LEN7_EXT16) begin
					phase_n = wsd_pkg::PH_EXT16;
				end else if (b[6:0] == wsd_pkg::LEN7_EXT64) begin
					phase_n = wsd_pkg::PH_EXT64;
				end else begin
					len_n        = LENGTH_BITS'(b[6:0]);
					do_after_len = 1'b1;
				end
			end
			wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
				len_n = len_push;
				cnt_n = cnt_q + 3'd1;
				if ((phase_q == wsd_pkg::PH_EXT16 && cnt_q == 3'd1) ||
				    (phase_q == wsd_pkg::PH_EXT64 && cnt_q == 3'd7)) begin
					do_after_len = 1'b1;
				end
			end
			wsd_pkg::PH_MASK: begin
				key_n = {key_q[23:0], b};
				cnt_n = cnt_q + 3'd1;
				if (cnt_q == 3'd3) begin
					cnt_n       = '0;
					do_hdr_done = 1'b1;
				end
			end
			wsd_pkg::PH_PAYLOAD: begin
				idx_n = idx_q + 2'd1;
				len_n = len_q - LENGTH_BITS'(1);
				if (len_q[LENGTH_BITS-1:1] == '0) begin
					do_end = 1'b1;
					end_d  = d;
					end_v  = 1'b1;
				end else if (op_q != wsd_pkg::OP_CLOSE) begin
					gen            = 1'b1;
					res.data       = d;
					res.data_valid = 1'b1;
				end
			end
			wsd_pkg::PH_CLOSED: begin
				// stream is dead until reset
			end
			default: begin
				fin_n   = b[7];
				op_n    = b[3:0];
				phase_n = wsd_pkg::PH_HDR1;
			end
		endcase

		if (do_after_len) begin
			cnt_n = '0;
			if (mask_n) begin
				phase_n = wsd_pkg::PH_MASK;
			end else begin
				do_hdr_done = 1'b1;
			end
		end

		if (do_hdr_done) begin
			idx_n = '0;
			if (len_n == '0) begin
				do_end = 1'b1;
			end else begin
				phase_n = wsd_pkg::PH_PAYLOAD;
			end
		end

		if (do_end) begin
			gen      = 1'b1;
			res.last = 1'b1;
			if (op_q == wsd_pkg::OP_CLOSE) begin
				phase_n    = wsd_pkg::PH_CLOSED;
				res.closed = 1'b1;
			end else begin
				phase_n        = wsd_pkg::PH_HDR0;
				res.data       = end_d;
				res.data_valid = end_v;
			end
		end
	end

	// bytes without a result never wait on the output
	assign adv  = stage.vld && (!gen || slot_free);
	assign load = adv && gen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wsd_pkg::PH_HDR0;
			fin_q   <= 1'b0;
			op_q    <= '0;
			mask_q  <= 1'b0;
			len_q   <= '0;
			cnt_q   <= '0;
			key_q   <= '0;
			idx_q   <= '0;
		end else if (adv) begin
			phase_q <= phase_n;
			fin_q   <= fin_n;
			op_q    <= op_n;
			mask_q  <= mask_n;
			len_q   <= len_n;
			cnt_q   <= cnt_n;
			key_q   <= key_n;
			idx_q   <= idx_n;
		end
	end

endmodule

/* src/wsd_out_reg.sv */
// Result register: holds one result item until the sink takes it.
// Depends on wsd_pkg and wsd_frame_if.

module wsd_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  wsd_pkg::res_t res,
	output logic          slot_free,
	wsd_frame_if.source   frame
);

	logic          vld_q;
	wsd_pkg::res_t res_q;

	assign slot_free = !vld_q || frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (frame.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign frame.valid      = vld_q;
	assign frame.data       = res_q.data;
	assign frame.data_valid = res_q.data_valid;
	assign frame.last       = res_q.last;
	assign frame.opcode     = res_q.opcode;
	assign frame.fin        = res_q.fin;
	assign frame.closed     = res_q.closed;

endmodule

/* src/websocket_frame_deframer.sv */
// Top level of the WebSocket frame deframer (receive side).
// Depends on wsd_pkg, wsd_rx_if, wsd_frame_if, wsd_in_reg, wsd_parser, wsd_out_reg.
//
//  channel | dir | payload                                      | note
//  --------+-----+----------------------------------------------+---------------------------
//  rx      | in  | rx_byte[7:0]                                 | one stream byte per item
//  frame   | out | data, data_valid, last, opcode, fin, closed  | zero or one per rx item
//
// One byte per cycle while nothing stalls. An accepted byte sits in the input register, is
// parsed there and its result is loaded into the result register, which drives frame
// valid. Header, length and mask bytes give no item and never wait on the output, save
// the final header byte of a frame with an empty payload; only a byte with a result
// stalls while the result register is full and not being taken. arst_n clears
// the parse state to "expect first header byte" and empties both registers.

module websocket_frame_deframer #(
	parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF  // 16..64
) (
	input  logic        clk,
	input  logic        arst_n,
	wsd_rx_if.sink      rx,
	wsd_frame_if.source frame
);

	wsd_pkg::in_s1_t stage;
	wsd_pkg::res_t   res;
	logic            adv;
	logic            load;
	logic            slot_free;

	// byte capture
	wsd_in_reg u_in (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.adv    (adv),
		.stage  (stage)
	);

	// header parse, length tracking, unmasking; close-frame payload is swallowed and a closed item ends the stream
	wsd_parser #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage     (stage),
		.slot_free (slot_free),
		.adv       (adv),
		.load      (load),
		.res       (res)
	);

	// result holding register; decouples rx from frame backpressure
	wsd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res       (res),
		.slot_free (slot_free),
		.frame     (frame)
	);

endmodule
